// File: hw/rtl/cld_pkg.sv
// Types, codes and helper functions for the content-length message deframer.
package cld_pkg;

  localparam int LEN_BITS = 32;
  localparam int ACC_W    = LEN_BITS + 4;

  localparam logic [3:0] KEY_LEN = 4'd14;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic RK_PAYLOAD = 1'b0;
  localparam logic RK_STATUS  = 1'b1;

  localparam logic [2:0] ST_NONE    = 3'd0;
  localparam logic [2:0] ST_BAD     = 3'd1;
  localparam logic [2:0] ST_MISSING = 3'd2;
  localparam logic [2:0] ST_TRUNC   = 3'd3;
  localparam logic [2:0] ST_IDLE    = 3'd4;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] payload_byte;
    logic       last;
    logic [2:0] status;
  } result_t;

  typedef enum logic [3:0] {
    PH_HEADER   = 4'b0001,
    PH_PAYLOAD  = 4'b0010,
    PH_AFTER    = 4'b0100,
    PH_AFTER_CR = 4'b1000
  } phase_t;

  typedef enum logic [2:0] {
    LF_EMPTY  = 3'b001,
    LF_ONE_CR = 3'b010,
    LF_TEXT   = 3'b100
  } line_form_t;

  typedef enum logic [3:0] {
    KS_LEAD  = 4'b0001,
    KS_MATCH = 4'b0010,
    KS_TRAIL = 4'b0100,
    KS_MISS  = 4'b1000
  } key_state_t;

  typedef enum logic [5:0] {
    VS_LEAD   = 6'b000001,
    VS_SIGN   = 6'b000010,
    VS_DIGITS = 6'b000100,
    VS_DONE   = 6'b001000,
    VS_BAD    = 6'b010000,
    VS_IGNORE = 6'b100000
  } value_state_t;

  typedef struct packed {
    line_form_t          form;
    logic [3:0]          key_position;
    key_state_t          key_state;
    logic                colon_seen;
    value_state_t        value_state;
    logic [LEN_BITS-1:0] value_accumulator;
  } line_t;

  typedef struct packed {
    phase_t              phase;
    logic [LEN_BITS-1:0] length_register;
    logic [LEN_BITS-1:0] bytes_remaining;
    logic                header_started;
    line_t               line;
  } state_t;

  localparam line_t LINE_CLEAR = '{
    form:              LF_EMPTY,
    key_position:      4'd0,
    key_state:         KS_LEAD,
    colon_seen:        1'b0,
    value_state:       VS_LEAD,
    value_accumulator: '0
  };

  localparam state_t STATE_RESET = '{
    phase:           PH_HEADER,
    length_register: '0,
    bytes_remaining: '0,
    header_started:  1'b0,
    line:            LINE_CLEAR
  };

  function automatic logic [7:0] key_char(input logic [3:0] pos);
    logic [7:0] ch;
    case (pos)
      4'd0:    ch = "c";
      4'd1:    ch = "o";
      4'd2:    ch = "n";
      4'd3:    ch = "t";
      4'd4:    ch = "e";
      4'd5:    ch = "n";
      4'd6:    ch = "t";
      4'd7:    ch = "-";
      4'd8:    ch = "l";
      4'd9:    ch = "e";
      4'd10:   ch = "n";
      4'd11:   ch = "g";
      4'd12:   ch = "t";
      4'd13:   ch = "h";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] fold_char(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic result_t make_report(input logic [2:0] code);
    result_t r;
    r.result_kind  = RK_STATUS;
    r.payload_byte = 8'h00;
    r.last         = 1'b0;
    r.status       = code;
    return r;
  endfunction

endpackage

// File: hw/rtl/content_length_message_deframer.sv
// Content-length message deframer: splits a byte stream into message payloads.
//
// Takes one stream byte or end-of-stream marker per cycle and gives at most one
// result for it: a payload byte (last set on the final one) or a status report.
// Header parsing, the decimal length value (a multiply by ten and overflow
// compare) and the payload count all update in the cycle the request is taken,
// and the result lands in a single output register. A new request is taken
// every cycle while that register is empty or being drained, so throughput is
// one byte per cycle. There is no clearing pass after reset.
module content_length_message_deframer (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  cld_pkg::item_t    item,
  output logic              result_valid,
  input  logic              result_ready,
  output cld_pkg::result_t  result
);
  import cld_pkg::*;

  state_t              st;
  state_t              st_next;
  result_t             res_next;
  logic                res_fire;
  logic                accept;
  logic                hdr_go;

  logic [7:0]          c;
  logic                c_blank;
  logic                c_digit;

  key_state_t          ks_eff;
  key_state_t          ks_step;
  logic [3:0]          kp_step;
  logic                key_hit;

  value_state_t        vs_step;
  logic [LEN_BITS-1:0] acc_step;
  logic [LEN_BITS-1:0] acc_base;
  logic [ACC_W-1:0]    prod;
  logic                prod_ovf;

  logic                fin_take;
  logic                fin_good;
  logic                fin_bad;
  logic [LEN_BITS-1:0] fin_len;
  logic [LEN_BITS-1:0] rem_dec;

  assign c       = item.data_byte;
  assign c_blank = is_blank(c);
  assign c_digit = is_digit(c);

  assign accept     = item_valid && item_ready;
  assign item_ready = !result_valid || result_ready;

  assign ks_eff  = (st.line.key_state == KS_LEAD && !c_blank) ? KS_MATCH : st.line.key_state;
  assign key_hit = (st.line.key_state == KS_MATCH && st.line.key_position == KEY_LEN) ||
                   (st.line.key_state == KS_TRAIL);

  always_comb begin
    ks_step = st.line.key_state;
    kp_step = st.line.key_position;
    case (ks_eff)
      KS_MATCH: begin
        ks_step = KS_MATCH;
        if (c_blank) begin
          ks_step = (st.line.key_position == KEY_LEN) ? KS_TRAIL : KS_MISS;
        end else if (st.line.key_position < KEY_LEN &&
                     fold_char(c) == key_char(st.line.key_position)) begin
          kp_step = st.line.key_position + 4'd1;
        end else begin
          ks_step = KS_MISS;
        end
      end
      KS_TRAIL: begin
        if (!c_blank) begin
          ks_step = KS_MISS;
        end
      end
      default: ;
    endcase
  end

  assign acc_base = (st.line.value_state == VS_LEAD) ? '0 : st.line.value_accumulator;
  assign prod     = ({{(ACC_W-LEN_BITS){1'b0}}, acc_base} << 3) +
                    ({{(ACC_W-LEN_BITS){1'b0}}, acc_base} << 1) +
                    {{(ACC_W-4){1'b0}}, c[3:0]};
  assign prod_ovf = |prod[ACC_W-1:LEN_BITS];

  always_comb begin
    vs_step  = st.line.value_state;
    acc_step = st.line.value_accumulator;
    case (st.line.value_state)
      VS_LEAD: begin
        if (c_blank) begin
          vs_step = VS_LEAD;
        end else if (c == CH_PLUS) begin
          vs_step = VS_SIGN;
        end else if (!c_digit || prod_ovf) begin
          vs_step = VS_BAD;
        end else begin
          vs_step  = VS_DIGITS;
          acc_step = prod[LEN_BITS-1:0];
        end
      end
      VS_SIGN, VS_DIGITS: begin
        if (c_digit) begin
          if (prod_ovf) begin
            vs_step = VS_BAD;
          end else begin
            vs_step  = VS_DIGITS;
            acc_step = prod[LEN_BITS-1:0];
          end
        end else begin
          vs_step = (st.line.value_state == VS_SIGN) ? VS_BAD : VS_DONE;
        end
      end
      default: ;
    endcase
  end

  assign fin_take = st.line.colon_seen && st.line.value_state != VS_IGNORE;
  assign fin_good = st.line.value_state == VS_DIGITS || st.line.value_state == VS_DONE;
  assign fin_bad  = fin_take && !fin_good;
  assign fin_len  = (fin_take && fin_good) ? st.line.value_accumulator : st.length_register;
  assign rem_dec  = st.bytes_remaining - {{(LEN_BITS-1){1'b0}}, (st.bytes_remaining != '0)};

  always_comb begin
    st_next  = st;
    res_next = make_report(ST_NONE);
    res_fire = 1'b0;
    hdr_go   = 1'b0;

    if (item.kind == KIND_END) begin
      res_fire = 1'b1;
      st_next  = STATE_RESET;
      case (st.phase)
        PH_HEADER: begin
          if (st.line.form == LF_TEXT && fin_bad) begin
            res_next = make_report(ST_BAD);
          end else if (!st.header_started && st.line.form != LF_TEXT) begin
            res_next = make_report(ST_IDLE);
          end else if (((st.line.form == LF_TEXT) ? fin_len : st.length_register) == '0) begin
            res_next = make_report(ST_MISSING);
          end else begin
            res_next = make_report(ST_TRUNC);
          end
        end
        PH_PAYLOAD: res_next = make_report(ST_TRUNC);
        default:    res_next = make_report(ST_IDLE);
      endcase
    end else begin
      case (st.phase)
        PH_PAYLOAD: begin
          res_fire              = 1'b1;
          res_next.result_kind  = RK_PAYLOAD;
          res_next.payload_byte = c;
          res_next.last         = (rem_dec == '0);
          res_next.status       = ST_NONE;
          st_next.bytes_remaining = rem_dec;
          if (rem_dec == '0) begin
            st_next.phase = PH_AFTER;
          end
        end
        PH_AFTER: begin
          if (c == CH_CR) begin
            st_next.phase = PH_AFTER_CR;
          end else begin
            st_next.phase = PH_HEADER;
            hdr_go        = 1'b1;
          end
        end
        PH_AFTER_CR: begin
          st_next.phase = PH_HEADER;
          hdr_go        = (c != CH_LF);
        end
        default: hdr_go = 1'b1;
      endcase

      if (hdr_go) begin
        if (c == CH_LF) begin
          if (st.line.form == LF_TEXT) begin
            if (fin_bad) begin
              res_fire = 1'b1;
              res_next = make_report(ST_BAD);
              st_next  = STATE_RESET;
            end else begin
              st_next.length_register = fin_len;
              st_next.header_started  = 1'b1;
              st_next.line            = LINE_CLEAR;
            end
          end else begin
            st_next.line = LINE_CLEAR;
            if (st.length_register == '0) begin
              res_fire = 1'b1;
              res_next = make_report(ST_MISSING);
              st_next  = STATE_RESET;
            end else begin
              st_next.phase           = PH_PAYLOAD;
              st_next.bytes_remaining = st.length_register;
            end
          end
        end else begin
          st_next.line.form = (st.line.form == LF_EMPTY && c == CH_CR) ? LF_ONE_CR : LF_TEXT;
          if (!st.line.colon_seen) begin
            if (c == CH_COLON) begin
              st_next.line.colon_seen        = 1'b1;
              st_next.line.value_state       = key_hit ? VS_LEAD : VS_IGNORE;
              st_next.line.value_accumulator = '0;
            end else begin
              st_next.line.key_state    = ks_step;
              st_next.line.key_position = kp_step;
            end
          end else begin
            st_next.line.value_state       = vs_step;
            st_next.line.value_accumulator = acc_step;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= STATE_RESET;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        st           <= st_next;
        result_valid <= res_fire;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_fire) begin
      result <= res_next;
    end
  end

endmodule

// File: bench/tb_top.sv
// Self-checking bench for the content-length message deframer.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cld_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 2000;
  localparam logic [63:0] LEN_MAX = ((64'd1 << (LEN_BITS - 1)) << 1) - 64'd1;
  localparam logic [8*14-1:0] KEY_TEXT = "content-length";

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_ready;
  item_t   item = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  always #4 clk = ~clk;

  content_length_message_deframer uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  // Deframer model state
  phase_t              msg_phase;
  line_form_t          line_kind;
  logic [3:0]          key_pos;
  key_state_t          key_st;
  logic                colon_hit;
  value_state_t        val_st;
  logic [LEN_BITS-1:0] val_acc;
  logic [LEN_BITS-1:0] content_len;
  logic [LEN_BITS-1:0] remain;
  logic                hdr_started;

  result_t    frame_results[$];
  logic [7:0] frame_bytes[$];
  result_t    oldest;
  int         errors = 0;
  int         sent_count = 0;
  int         quiet_cycles = 0;
  int         hold_cnt = 0;
  int         stall_cnt = 0;
  bit         hold_taken = 1'b0;
  bit         hold_req = 1'b0;
  bit         rx_stall_en = 1'b1;
  bit         tx_gap_en = 1'b1;

  function automatic logic white_char(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic [7:0] key_letter(input logic [3:0] pos);
    return KEY_TEXT[8 * (int'(KEY_LEN) - 1 - int'(pos)) +: 8];
  endfunction

  function automatic void line_reset();
    line_kind = LF_EMPTY;
    key_pos   = 4'd0;
    key_st    = KS_LEAD;
    colon_hit = 1'b0;
    val_st    = VS_LEAD;
    val_acc   = '0;
  endfunction

  function automatic void msg_reset();
    line_reset();
    msg_phase   = PH_HEADER;
    content_len = '0;
    remain      = '0;
    hdr_started = 1'b0;
  endfunction

  function automatic bit close_line();
    bit bad;
    bad = 1'b0;
    if (colon_hit && val_st != VS_IGNORE) begin
      if (val_st == VS_DIGITS || val_st == VS_DONE) content_len = val_acc;
      else bad = 1'b1;
    end
    hdr_started = 1'b1;
    line_reset();
    return bad;
  endfunction

  task automatic push_report(input logic [2:0] code);
    result_t r;
    msg_reset();
    r.result_kind  = RK_STATUS;
    r.payload_byte = 8'h00;
    r.last         = 1'b0;
    r.status       = code;
    frame_results.push_back(r);
  endtask

  task automatic deframe_step(input item_t it);
    logic [7:0]  c;
    logic [7:0]  lc;
    logic [63:0] d;
    logic        dig;
    logic        take;
    logic        bad;
    result_t     r;
    c = it.data_byte;
    if (it.kind == KIND_END) begin
      bad = 1'b0;
      if (msg_phase == PH_HEADER) begin
        if (line_kind == LF_TEXT) bad = close_line();
        if (bad) push_report(ST_BAD);
        else if (!hdr_started) push_report(ST_IDLE);
        else if (content_len == 0) push_report(ST_MISSING);
        else push_report(ST_TRUNC);
      end else if (msg_phase == PH_PAYLOAD) begin
        push_report(ST_TRUNC);
      end else begin
        push_report(ST_IDLE);
      end
      return;
    end
    if (msg_phase == PH_PAYLOAD) begin
      if (remain != 0) remain = remain - 1'b1;
      r.result_kind  = RK_PAYLOAD;
      r.payload_byte = c;
      r.last         = (remain == 0);
      r.status       = ST_NONE;
      frame_results.push_back(r);
      if (remain == 0) msg_phase = PH_AFTER;
      return;
    end
    // skip one optional CR, and an LF that follows it, after the payload
    if (msg_phase == PH_AFTER) begin
      if (c == CH_CR) begin
        msg_phase = PH_AFTER_CR;
        return;
      end
      msg_phase = PH_HEADER;
    end else if (msg_phase == PH_AFTER_CR) begin
      msg_phase = PH_HEADER;
      if (c == CH_LF) return;
    end
    if (c == CH_LF) begin
      if (line_kind == LF_TEXT) begin
        if (close_line()) push_report(ST_BAD);
        return;
      end
      line_reset();
      if (content_len == 0) begin
        push_report(ST_MISSING);
        return;
      end
      msg_phase = PH_PAYLOAD;
      remain    = content_len;
      return;
    end
    line_kind = (line_kind == LF_EMPTY && c == CH_CR) ? LF_ONE_CR : LF_TEXT;
    if (!colon_hit) begin
      if (c == CH_COLON) begin
        colon_hit = 1'b1;
        val_st = ((key_st == KS_MATCH && key_pos == KEY_LEN) || key_st == KS_TRAIL) ?
                 VS_LEAD : VS_IGNORE;
        val_acc = '0;
      end else begin
        lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        if (key_st == KS_LEAD && !white_char(c)) key_st = KS_MATCH;
        if (key_st == KS_MATCH) begin
          if (white_char(c)) key_st = (key_pos == KEY_LEN) ? KS_TRAIL : KS_MISS;
          else if (key_pos < KEY_LEN && lc == key_letter(key_pos)) key_pos = key_pos + 1'b1;
          else key_st = KS_MISS;
        end else if (key_st == KS_TRAIL && !white_char(c)) begin
          key_st = KS_MISS;
        end
      end
    end else begin
      dig  = (c >= "0" && c <= "9");
      take = 1'b0;
      if (val_st == VS_LEAD && !white_char(c)) begin
        if (c == CH_PLUS) val_st = VS_SIGN;
        else if (!dig) val_st = VS_BAD;
        else begin
          val_st  = VS_DIGITS;
          val_acc = '0;
          take    = 1'b1;
        end
      end else if (val_st == VS_SIGN || val_st == VS_DIGITS) begin
        if (dig) take = 1'b1;
        else val_st = (val_st == VS_SIGN) ? VS_BAD : VS_DONE;
      end
      if (take) begin
        d = 64'(c - 8'h30);
        val_st = VS_DIGITS;
        if (64'(val_acc) > (LEN_MAX - d) / 64'd10) val_st = VS_BAD;
        else val_acc = LEN_BITS'(64'(val_acc) * 64'd10 + d);
      end
    end
  endtask

  // Sender side
  task automatic send_request(input item_t it);
    item       <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    deframe_step(it);
    sent_count++;
    if (tx_gap_en && $urandom_range(0, 5) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    item_t it;
    it.kind      = KIND_BYTE;
    it.data_byte = b;
    send_request(it);
  endtask

  task automatic send_end();
    item_t it;
    it.kind      = KIND_END;
    it.data_byte = 8'($urandom);
    send_request(it);
  endtask

  task automatic flush_frame(input int upto);
    for (int i = 0; i < upto && i < frame_bytes.size(); i++) send_byte(frame_bytes[i]);
    frame_bytes.delete();
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) frame_bytes.push_back(s[i]);
  endtask

  task automatic add_key(input string k);
    logic [7:0] ch;
    for (int i = 0; i < k.len(); i++) begin
      ch = k[i];
      if (ch >= "a" && ch <= "z" && $urandom_range(0, 1)) ch = ch - 8'd32;
      frame_bytes.push_back(ch);
    end
  endtask

  task automatic add_blanks(input int hi);
    logic [7:0] b;
    repeat ($urandom_range(0, hi)) begin
      case ($urandom_range(0, 4))
        0:       b = 8'h09;
        1:       b = 8'h0B;
        2:       b = 8'h0C;
        3:       b = CH_CR;
        default: b = 8'h20;
      endcase
      frame_bytes.push_back(b);
    end
  endtask

  task automatic add_eol(input bit with_cr);
    if (with_cr) frame_bytes.push_back(CH_CR);
    frame_bytes.push_back(CH_LF);
  endtask

  task automatic add_length_line(input string v);
    add_blanks(2);
    add_key("content-length");
    add_blanks(1);
    frame_bytes.push_back(CH_COLON);
    add_blanks(2);
    add_text(v);
    add_eol($urandom_range(0, 1));
  endtask

  task automatic add_other_header();
    bit keyed;
    keyed = 1'b1;
    case ($urandom_range(0, 6))
      0: add_key("content-type");
      1: add_key("content-lengthx");
      2: add_key("content-lengt");
      3: add_text("content length");
      4: add_key("x-content-length");
      5: begin
        add_key("content-len");
        frame_bytes.push_back(8'hE7);
        add_text("th");
      end
      default: begin
        add_text("no colon here");
        keyed = 1'b0;
      end
    endcase
    if (keyed) begin
      frame_bytes.push_back(CH_COLON);
      add_blanks(1);
      add_text("7 ");
    end
    add_eol($urandom_range(0, 1));
  endtask

  task automatic send_random_message();
    int    n;
    string v;
    n = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
    v = $sformatf("%0d", n);
    case ($urandom_range(0, 7))
      0:       v = {"+", v};
      1:       v = {"00", v};
      2:       v = {v, " ; q"};
      3:       v = {v, "x9"};
      default: ;
    endcase
    if ($urandom_range(0, 1)) add_other_header();
    case ($urandom_range(0, 19))
      0:       add_length_line("4294967295");
      1:       add_length_line("0");
      2:       v = "-4";
      3:       v = "";
      4:       v = "+";
      5:       v = "4294967296";
      6:       v = "0";
      7:       v = "abc";
      8:       v = "99999999999";
      default: ;
    endcase
    add_length_line(v);
    if ($urandom_range(0, 2) == 0) add_other_header();
    add_eol($urandom_range(0, 1));
    repeat (n) frame_bytes.push_back(8'($urandom));
    case ($urandom_range(0, 3))
      0: add_eol(1'b1);
      1: frame_bytes.push_back(CH_CR);
      2: frame_bytes.push_back(CH_LF);
      default: ;
    endcase
    if ($urandom_range(0, 9) == 0) begin
      flush_frame($urandom_range(0, frame_bytes.size()));
      send_end();
    end else begin
      flush_frame(frame_bytes.size());
      if ($urandom_range(0, 3) == 0) send_end();
    end
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 16)) begin
      case ($urandom_range(0, 5))
        0:       frame_bytes.push_back(CH_LF);
        1:       frame_bytes.push_back(CH_CR);
        2:       frame_bytes.push_back(CH_COLON);
        3:       frame_bytes.push_back(8'h30 + 8'($urandom_range(0, 9)));
        4:       frame_bytes.push_back(CH_PLUS);
        default: frame_bytes.push_back(8'($urandom));
      endcase
    end
    flush_frame(frame_bytes.size());
    if ($urandom_range(0, 1)) send_end();
  endtask

  // Directed tests
  task automatic test_end_of_stream();
    send_end();
    send_byte("x");
    send_end();
  endtask

  task automatic test_blank_lines();
    add_eol(1'b0);
    add_eol(1'b1);
    flush_frame(frame_bytes.size());
  endtask

  task automatic test_simple_message();
    add_text(" Content-LENGTH\t:+2 ok");
    add_eol(1'b1);
    add_eol(1'b1);
    frame_bytes.push_back(8'hFF);
    frame_bytes.push_back(8'h00);
    add_eol(1'b1);
    flush_frame(frame_bytes.size());
    send_end();
  endtask

  task automatic test_bad_values();
    add_text("content-length:-1");
    add_eol(1'b0);
    add_text("CONTENT-LENGTH :");
    add_eol(1'b0);
    add_text("content-length:4294967296");
    flush_frame(frame_bytes.size());
    send_end();
  endtask

  task automatic test_length_limits();
    add_text("content-length:4294967295");
    add_eol(1'b0);
    add_eol(1'b0);
    frame_bytes.push_back("z");
    flush_frame(frame_bytes.size());
    send_end();
    add_text("content-length: 1");
    add_eol(1'b0);
    add_text("content-length:0");
    add_eol(1'b0);
    add_eol(1'b0);
    flush_frame(frame_bytes.size());
    send_end();
  endtask

  task automatic test_non_ascii_key();
    add_text("content-len");
    frame_bytes.push_back(8'hE7);
    add_text("th:5");
    add_eol(1'b0);
    add_eol(1'b0);
    flush_frame(frame_bytes.size());
    send_end();
  endtask

  // Random and pressure tests
  task automatic test_random_traffic();
    while (sent_count < 1000) begin
      if ($urandom_range(0, 7) == 0) send_noise();
      else send_random_message();
    end
  endtask

  task automatic test_output_hold();
    hold_req <= 1'b1;
    add_length_line("40");
    add_eol(1'b1);
    repeat (40) frame_bytes.push_back(8'($urandom));
    flush_frame(frame_bytes.size());
    hold_req <= 1'b0;
  endtask

  task automatic test_drain_pause();
    send_random_message();
    item_valid <= 1'b0;
    while (frame_results.size() != 0) @(posedge clk);
    send_random_message();
  endtask

  task automatic test_steady_stream();
    int stop_at;
    stop_at     = sent_count + 150;
    tx_gap_en   = 1'b0;
    rx_stall_en <= 1'b0;
    while (sent_count < stop_at) send_random_message();
    send_end();
  endtask

  initial begin
    msg_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_end_of_stream();
    test_blank_lines();
    test_simple_message();
    test_bad_values();
    test_length_limits();
    test_non_ascii_key();
    test_random_traffic();
    test_output_hold();
    test_drain_pause();
    test_steady_stream();
    item_valid <= 1'b0;
    while (frame_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("[content_length_message_deframer] OK");
    end else begin
      $display("[content_length_message_deframer] ERROR");
    end
    $finish;
  end

  // Receiver: check each result, then drive ready for the next cycle
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (frame_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result kind=%0d byte=%02h last=%0d status=%0d", $time,
                 result.result_kind, result.payload_byte, result.last, result.status);
      end else begin
        oldest = frame_results.pop_front();
        if (result.result_kind !== oldest.result_kind ||
            result.payload_byte !== oldest.payload_byte ||
            result.last !== oldest.last || result.status !== oldest.status) begin
          errors++;
          $display({"%0t: mismatch expected kind=%0d byte=%02h last=%0d status=%0d,",
                    " actual kind=%0d byte=%02h last=%0d status=%0d"},
                   $time, oldest.result_kind, oldest.payload_byte, oldest.last, oldest.status,
                   result.result_kind, result.payload_byte, result.last, result.status);
        end
      end
    end
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_cnt   = HOLD_CYCLES;
    end else if (!hold_req) begin
      hold_taken = 1'b0;
    end
    if (hold_cnt != 0) begin
      hold_cnt--;
      result_ready <= 1'b0;
    end else if (stall_cnt != 0) begin
      stall_cnt--;
      result_ready <= 1'b0;
    end else if (rx_stall_en && $urandom_range(0, 6) == 0) begin
      stall_cnt = $urandom_range(0, 9);
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((item_valid && item_ready) || (result_valid && result_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[content_length_message_deframer] ERROR");
      $finish;
    end
  end

endmodule
